// ----- design/llp_pkg.sv -----
// ----------------------------------------------------------------------------
// llp_pkg: shared definitions for the LL(1) grammar parser
// Sizes, character codes, status codes, register indexes and the structs
// that pass between the rule table, the stack unit and the top level.
// ----------------------------------------------------------------------------
package llp_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_RULES   = 4;
    localparam int MAX_RHS     = 3;
    localparam int RULE_REGS   = 4;

    localparam int SYM_W      = 8;
    localparam int RULE_W     = 34;
    localparam int LEN_W      = 2;
    localparam int COUNT_W    = $clog2(STACK_DEPTH + 2);
    localparam int PTR_W      = $clog2(STACK_DEPTH);
    localparam int RULE_IDX_W = $clog2(RULE_REGS);
    localparam int CFG_IDX_W  = 3;
    localparam int FIRED_W    = 3;
    localparam int STATUS_W   = 3;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_RHS);

    localparam logic [SYM_W-1:0] END_MARK      = 8'd35;  // '#'
    localparam logic [SYM_W-1:0] NT_LOW        = 8'd65;  // 'A'
    localparam logic [SYM_W-1:0] NT_HIGH       = 8'd90;  // 'Z'
    localparam logic [SYM_W-1:0] START_DEFAULT = 8'd83;  // 'S'

    localparam logic [RULE_W-1:0] RULE_ONE_DEFAULT   = 34'd21857875;
    localparam logic [RULE_W-1:0] RULE_TWO_DEFAULT   = 34'd6660918099;
    localparam logic [RULE_W-1:0] RULE_THREE_DEFAULT = 34'd6660918081;
    localparam logic [RULE_W-1:0] RULE_FOUR_DEFAULT  = 34'd102721;

    localparam logic [CFG_IDX_W-1:0] REG_RULE_ONE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_TWO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_THREE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_FOUR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_SYMBOL = 3'd4;

    localparam logic [STATUS_W-1:0] ST_CONSUMED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DECIDED  = 3'd5;

    typedef struct packed {
        logic                  rules_ok;
        logic                  found;
        logic [RULE_IDX_W-1:0] idx;
        logic [LEN_W-1:0]      len;
        logic [SYM_W-1:0]      rhs1;
        logic [SYM_W-1:0]      rhs2;
    } lookup_t;

    typedef struct packed {
        logic [FIRED_W-1:0]  rule_fired;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// ----- design/llp_rule_table.sv -----
// ----------------------------------------------------------------------------
// llp_rule_table: rule registers, rule check and rule lookup
// Holds the packed rules and the start symbol, checks the rule set and
// finds the last rule whose left side and first character match.
// ----------------------------------------------------------------------------
module llp_rule_table
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [llp_pkg::CFG_IDX_W-1:0]   reg_index,
    input  logic [llp_pkg::RULE_W-1:0]      wr_data,
    input  logic [llp_pkg::SYM_W-1:0]       top_sym,
    input  logic [llp_pkg::SYM_W-1:0]       cur_sym,
    output logic [llp_pkg::SYM_W-1:0]       start_symbol,
    output llp_pkg::lookup_t                lookup
);

    logic [llp_pkg::RULE_W-1:0] rule_reg [llp_pkg::RULE_REGS];
    logic [llp_pkg::SYM_W-1:0]  start_reg;

    logic [llp_pkg::SYM_W-1:0]  lhs  [llp_pkg::RULE_REGS];
    logic [llp_pkg::LEN_W-1:0]  len  [llp_pkg::RULE_REGS];
    logic [llp_pkg::SYM_W-1:0]  ch0  [llp_pkg::RULE_REGS];
    logic [llp_pkg::SYM_W-1:0]  ch1  [llp_pkg::RULE_REGS];
    logic [llp_pkg::SYM_W-1:0]  ch2  [llp_pkg::RULE_REGS];
    logic                       used [llp_pkg::RULE_REGS];

    logic                            rules_ok;
    logic                            found;
    logic [llp_pkg::RULE_IDX_W-1:0]  found_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_reg[0] <= llp_pkg::RULE_ONE_DEFAULT;
            rule_reg[1] <= llp_pkg::RULE_TWO_DEFAULT;
            rule_reg[2] <= llp_pkg::RULE_THREE_DEFAULT;
            rule_reg[3] <= llp_pkg::RULE_FOUR_DEFAULT;
            start_reg   <= llp_pkg::START_DEFAULT;
        end
        else if (wr_en)
        begin
            case (reg_index)
                llp_pkg::REG_RULE_ONE:     rule_reg[0] <= wr_data;
                llp_pkg::REG_RULE_TWO:     rule_reg[1] <= wr_data;
                llp_pkg::REG_RULE_THREE:   rule_reg[2] <= wr_data;
                llp_pkg::REG_RULE_FOUR:    rule_reg[3] <= wr_data;
                llp_pkg::REG_START_SYMBOL: start_reg   <= wr_data[llp_pkg::SYM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        for (int r = 0; r < llp_pkg::RULE_REGS; r++)
        begin
            lhs[r] = rule_reg[r][7:0];
            len[r] = (rule_reg[r][9:8] > llp_pkg::LEN_MAX) ? llp_pkg::LEN_MAX
                                                             : rule_reg[r][9:8];
            ch0[r] = rule_reg[r][17:10];
            ch1[r] = rule_reg[r][25:18];
            ch2[r] = rule_reg[r][33:26];
            used[r] = (r < llp_pkg::NUM_RULES) && (lhs[r] != '0) && (len[r] != '0);
        end
    end

    // A used rule must start with a terminal, and two used rules with the
    // same left side must not share a first character.
    always_comb
    begin
        rules_ok = 1'b1;
        for (int i = 0; i < llp_pkg::RULE_REGS; i++)
        begin
            if (used[i])
            begin
                if (ch0[i] >= llp_pkg::NT_LOW && ch0[i] <= llp_pkg::NT_HIGH)
                    rules_ok = 1'b0;
                for (int j = i + 1; j < llp_pkg::RULE_REGS; j++)
                begin
                    if (used[j] && lhs[j] == lhs[i] && ch0[j] == ch0[i])
                        rules_ok = 1'b0;
                end
            end
        end
    end

    // The highest numbered matching rule wins.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int r = 0; r < llp_pkg::RULE_REGS; r++)
        begin
            if (used[r] && lhs[r] == top_sym && ch0[r] == cur_sym)
            begin
                found     = 1'b1;
                found_idx = llp_pkg::RULE_IDX_W'(r);
            end
        end
    end

    assign start_symbol    = start_reg;
    assign lookup.rules_ok = rules_ok;
    assign lookup.found    = found;
    assign lookup.idx      = found_idx;
    assign lookup.len      = len[found_idx];
    assign lookup.rhs1     = ch1[found_idx];
    assign lookup.rhs2     = ch2[found_idx];

endmodule

// ----- design/llp_stack.sv -----
// ----------------------------------------------------------------------------
// llp_stack: symbol stack, stack count and word verdict
// Works out one parse step from the top of stack and the rule lookup, and
// commits the new stack, count and verdict when the step is taken.
// ----------------------------------------------------------------------------
module llp_stack
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        word_start,
    input  logic [llp_pkg::SYM_W-1:0]   cur_sym,
    input  logic [llp_pkg::SYM_W-1:0]   start_symbol,
    input  llp_pkg::lookup_t            lookup,
    output logic [llp_pkg::SYM_W-1:0]   top_sym,
    output llp_pkg::result_t            result
);

    logic [llp_pkg::SYM_W-1:0]    stack_reg  [llp_pkg::STACK_DEPTH];
    logic [llp_pkg::SYM_W-1:0]    stack_eff  [llp_pkg::STACK_DEPTH];
    logic [llp_pkg::SYM_W-1:0]    stack_next [llp_pkg::STACK_DEPTH];
    logic [llp_pkg::COUNT_W-1:0]  count_reg, count_eff, count_next;
    logic [llp_pkg::STATUS_W-1:0] verdict_reg, verdict_eff, verdict_next;

    logic [llp_pkg::COUNT_W-1:0]  top_pos;
    logic [llp_pkg::COUNT_W:0]    need;
    logic                         is_end;
    logic                         w0, w1, w2;
    logic [llp_pkg::SYM_W-1:0]    v0, v1;
    logic [llp_pkg::COUNT_W-1:0]  p1, p2;

    // A new word starts from the start symbol over the end marker.
    always_comb
    begin
        for (int i = 0; i < llp_pkg::STACK_DEPTH; i++)
            stack_eff[i] = stack_reg[i];
        if (word_start)
        begin
            stack_eff[0] = llp_pkg::END_MARK;
            stack_eff[1] = start_symbol;
        end
        count_eff   = word_start ? llp_pkg::COUNT_W'(2) : count_reg;
        verdict_eff = word_start ? llp_pkg::ST_CONSUMED : verdict_reg;
    end

    assign top_pos = count_eff - llp_pkg::COUNT_W'(1);
    assign top_sym = stack_eff[top_pos[llp_pkg::PTR_W-1:0]];
    assign is_end  = (cur_sym == llp_pkg::END_MARK);
    assign need    = {1'b0, top_pos} + (llp_pkg::COUNT_W+1)'(lookup.len);
    assign p1      = count_eff;
    assign p2      = count_eff + llp_pkg::COUNT_W'(1);

    // The top is replaced by rhs[len-1] .. rhs[1]; rhs[0] matches the
    // character. An end marker goes on top when the rule starts with '#'.
    always_comb
    begin
        w0 = 1'b0;
        w1 = 1'b0;
        w2 = 1'b0;
        v0 = llp_pkg::END_MARK;
        v1 = llp_pkg::END_MARK;
        case (lookup.len)
            2'd3:
            begin
                w0 = 1'b1;
                v0 = lookup.rhs2;
                w1 = 1'b1;
                v1 = lookup.rhs1;
                w2 = is_end;
            end
            2'd2:
            begin
                w0 = 1'b1;
                v0 = lookup.rhs1;
                w1 = is_end;
            end
            default:
            begin
                w0 = is_end;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < llp_pkg::STACK_DEPTH; i++)
            stack_next[i] = stack_eff[i];
        count_next        = count_eff;
        verdict_next      = verdict_eff;
        result.rule_fired = '0;
        result.status     = llp_pkg::ST_CONSUMED;

        if (!lookup.rules_ok)
        begin
            result.status = llp_pkg::ST_INVALID;
        end
        else if (verdict_eff != llp_pkg::ST_CONSUMED)
        begin
            result.status = llp_pkg::ST_DECIDED;
        end
        else if (count_eff == '0)
        begin
            verdict_next  = llp_pkg::ST_REJECT;
            result.status = llp_pkg::ST_REJECT;
        end
        else if (is_end && top_sym == llp_pkg::END_MARK)
        begin
            verdict_next  = llp_pkg::ST_ACCEPT;
            result.status = llp_pkg::ST_ACCEPT;
        end
        else if (cur_sym == top_sym)
        begin
            count_next = top_pos;
        end
        else if (!lookup.found)
        begin
            verdict_next  = llp_pkg::ST_REJECT;
            result.status = llp_pkg::ST_REJECT;
        end
        else if (need > (llp_pkg::COUNT_W+1)'(llp_pkg::STACK_DEPTH))
        begin
            verdict_next  = llp_pkg::ST_OVERFLOW;
            result.status = llp_pkg::ST_OVERFLOW;
        end
        else
        begin
            result.rule_fired = llp_pkg::FIRED_W'(lookup.idx) + llp_pkg::FIRED_W'(1);
            // Positions past the top of the array never match an entry.
            for (int i = 0; i < llp_pkg::STACK_DEPTH; i++)
            begin
                if (w0 && top_pos == llp_pkg::COUNT_W'(i))
                    stack_next[i] = v0;
                if (w1 && p1 == llp_pkg::COUNT_W'(i))
                    stack_next[i] = v1;
                if (w2 && p2 == llp_pkg::COUNT_W'(i))
                    stack_next[i] = llp_pkg::END_MARK;
            end
            count_next = count_eff + llp_pkg::COUNT_W'(lookup.len)
                       - llp_pkg::COUNT_W'(2) + llp_pkg::COUNT_W'(is_end);
            if (is_end)
            begin
                verdict_next  = llp_pkg::ST_ACCEPT;
                result.status = llp_pkg::ST_ACCEPT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 2; i < llp_pkg::STACK_DEPTH; i++)
                stack_reg[i] <= '0;
            stack_reg[0] <= llp_pkg::END_MARK;
            stack_reg[1] <= llp_pkg::START_DEFAULT;
            count_reg    <= llp_pkg::COUNT_W'(2);
            verdict_reg  <= llp_pkg::ST_CONSUMED;
        end
        else if (step)
        begin
            for (int i = 0; i < llp_pkg::STACK_DEPTH; i++)
                stack_reg[i] <= stack_next[i];
            count_reg   <= count_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule

// ----- design/ll1_simple_grammar_parser.sv -----
// ----------------------------------------------------------------------------
// ll1_simple_grammar_parser: predictive LL(1) parser, one character a word
// Input register, one parse step, result register; rules set by registers.
// ----------------------------------------------------------------------------
// Each input word carries one character of a sentence; word_start begins a
// new sentence with the start symbol over the end marker '#'. Every input
// word yields one result word with the rule applied and a status code. The
// block takes one word per clock unless the result side stalls; a word is held
// in the input register, its result in the result register. The stack update
// sets the rate: it must finish before the next character sees the top of stack.
// Rule and start symbol registers may be written only while no word is in flight.
module ll1_simple_grammar_parser
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [llp_pkg::CFG_IDX_W-1:0]   reg_index,
    input  logic [llp_pkg::RULE_W-1:0]      wr_data,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [llp_pkg::SYM_W-1:0]       symbol,
    input  logic                            word_start,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [llp_pkg::FIRED_W-1:0]     rule_fired,
    output logic [llp_pkg::STATUS_W-1:0]    status
);

    logic                         hold_valid_reg;
    logic [llp_pkg::SYM_W-1:0]    sym_reg;
    logic                         start_reg;
    logic                         out_valid_reg;
    llp_pkg::result_t             out_reg;

    logic                         advance;
    logic                         item_take;
    logic [llp_pkg::SYM_W-1:0]    top_sym;
    logic [llp_pkg::SYM_W-1:0]    start_symbol;
    llp_pkg::lookup_t             lookup;
    llp_pkg::result_t             step_result;

    // The held word moves on whenever the result register is free or drains.
    assign advance    = hold_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !hold_valid_reg || advance;
    assign item_take  = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_take)
                hold_valid_reg <= 1'b1;
            else if (advance)
                hold_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            sym_reg   <= symbol;
            start_reg <= word_start;
        end
        if (advance)
            out_reg <= step_result;
    end

    llp_rule_table u_rule_table
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .reg_index    (reg_index),
        .wr_data      (wr_data),
        .top_sym      (top_sym),
        .cur_sym      (sym_reg),
        .start_symbol (start_symbol),
        .lookup       (lookup)
    );

    llp_stack u_stack
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .word_start   (start_reg),
        .cur_sym      (sym_reg),
        .start_symbol (start_symbol),
        .lookup       (lookup),
        .top_sym      (top_sym),
        .result       (step_result)
    );

    assign result_valid = out_valid_reg;
    assign rule_fired   = out_reg.rule_fired;
    assign status       = out_reg.status;

endmodule

// ----- test/parse_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// parse_checker: scoreboard for the LL(1) grammar parser
// Follows the register port and the character channel, runs its own copy of
// the parse stack and rule table, and compares every result word in order.
// ----------------------------------------------------------------------------
module parse_checker
    import llp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] reg_index,
    input  logic [RULE_W-1:0]    wr_data,
    input  logic                 item_valid,
    input  logic                 item_ready,
    input  logic [SYM_W-1:0]     symbol,
    input  logic                 word_start,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  logic [FIRED_W-1:0]   rule_fired,
    input  logic [STATUS_W-1:0]  status,
    output int                   fail_count,
    output int                   pending
);

    localparam logic [STATUS_W-1:0] STILL_PARSING = 3'd0;

    logic [RULE_W-1:0]   rule_reg [RULE_REGS];
    logic [SYM_W-1:0]    start_sym;
    logic [SYM_W-1:0]    sym_stack [STACK_DEPTH];
    int                  depth;
    logic [STATUS_W-1:0] verdict;
    result_t             predicted_results [$];

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    function automatic void restart_word();
        for (int i = 0; i < STACK_DEPTH; i++)
            sym_stack[i] = '0;
        sym_stack[0] = END_MARK;
        sym_stack[1] = start_sym;
        depth = 2;
        verdict = STILL_PARSING;
    endfunction

    // A rule with a zero left side or zero length takes no part at all.
    function automatic bit rule_active(input int r);
        return r < NUM_RULES && rule_reg[r][7:0] != '0 && rule_reg[r][9:8] != '0;
    endfunction

    function automatic logic [SYM_W-1:0] rhs_char(input int r, input int k);
        return rule_reg[r][10 + 8 * k +: 8];
    endfunction

    function automatic int rhs_len(input int r);
        int n = rule_reg[r][9:8];
        return (n > MAX_RHS) ? MAX_RHS : n;
    endfunction

    // Every active rule must start with a terminal, and no two active rules
    // with the same left side may start with the same character.
    function automatic bit grammar_ok();
        for (int i = 0; i < RULE_REGS; i++)
        begin
            if (rule_active(i))
            begin
                if (rhs_char(i, 0) >= NT_LOW && rhs_char(i, 0) <= NT_HIGH)
                    return 1'b0;
                for (int j = i + 1; j < RULE_REGS; j++)
                begin
                    if (rule_active(j) && rule_reg[j][7:0] == rule_reg[i][7:0] &&
                        rhs_char(j, 0) == rhs_char(i, 0))
                        return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic result_t parse_char(input logic [SYM_W-1:0] sym, input logic restart);
        result_t          res;
        logic [SYM_W-1:0] top;
        int               found;
        int               len;
        res.rule_fired = '0;
        res.status = ST_CONSUMED;
        if (restart)
            restart_word();
        if (!grammar_ok())
            res.status = ST_INVALID;
        else if (verdict != STILL_PARSING)
            res.status = ST_DECIDED;
        else if (depth == 0)
        begin
            verdict = ST_REJECT;
            res.status = ST_REJECT;
        end
        else
        begin
            top = sym_stack[depth - 1];
            if (sym == END_MARK && top == END_MARK)
            begin
                verdict = ST_ACCEPT;
                res.status = ST_ACCEPT;
            end
            else if (sym == top)
                depth--;
            else
            begin
                found = -1;
                for (int r = 0; r < RULE_REGS; r++)
                begin
                    if (rule_active(r) && rule_reg[r][7:0] == top && rhs_char(r, 0) == sym)
                        found = r;
                end
                if (found < 0)
                begin
                    verdict = ST_REJECT;
                    res.status = ST_REJECT;
                end
                else
                begin
                    len = rhs_len(found);
                    if (depth - 1 + len > STACK_DEPTH)
                    begin
                        verdict = ST_OVERFLOW;
                        res.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        res.rule_fired = FIRED_W'(found + 1);
                        depth--;
                        // The first right-side character is the one just read.
                        for (int k = len - 1; k >= 1; k--)
                        begin
                            sym_stack[depth] = rhs_char(found, k);
                            depth++;
                        end
                        if (sym == END_MARK)
                        begin
                            sym_stack[depth] = END_MARK;
                            depth++;
                            verdict = ST_ACCEPT;
                            res.status = ST_ACCEPT;
                        end
                    end
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            rule_reg[0] = RULE_ONE_DEFAULT;
            rule_reg[1] = RULE_TWO_DEFAULT;
            rule_reg[2] = RULE_THREE_DEFAULT;
            rule_reg[3] = RULE_FOUR_DEFAULT;
            start_sym = START_DEFAULT;
            restart_word();
            predicted_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (reg_index)
                    REG_RULE_ONE:     rule_reg[0] = wr_data;
                    REG_RULE_TWO:     rule_reg[1] = wr_data;
                    REG_RULE_THREE:   rule_reg[2] = wr_data;
                    REG_RULE_FOUR:    rule_reg[3] = wr_data;
                    REG_START_SYMBOL: start_sym = wr_data[SYM_W-1:0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                want = parse_char(symbol, word_start);
                predicted_results.insert(predicted_results.size(), want);
            end
            if (result_valid && result_ready)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch($sformatf("result word with nothing pending (rule %0d, status %0d)",
                                              rule_fired, status));
                else
                begin
                    want = predicted_results.pop_front();
                    if (rule_fired !== want.rule_fired)
                        report_mismatch($sformatf("rule_fired %0d, predicted %0d",
                                                  rule_fired, want.rule_fired));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  status, want.status));
                end
            end
            pending = predicted_results.size();
        end
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus for the LL(1) grammar parser
// Feeds sentences through several rule sets, with random idling on both
// channels and one long result stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

    import llp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [SYM_W-1:0] LC_A = "a";
    localparam logic [SYM_W-1:0] LC_B = "b";
    localparam logic [SYM_W-1:0] LC_C = "c";
    localparam logic [SYM_W-1:0] LC_D = "d";
    localparam logic [SYM_W-1:0] LC_Q = "q";
    localparam logic [SYM_W-1:0] LC_X = "x";
    localparam logic [SYM_W-1:0] LC_Y = "y";
    localparam logic [SYM_W-1:0] UC_A = "A";
    localparam logic [SYM_W-1:0] UC_B = "B";
    localparam logic [SYM_W-1:0] UC_S = "S";

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             ws;
    } char_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] reg_index = '0;
    logic [RULE_W-1:0]    wr_data = '0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    logic [SYM_W-1:0]     symbol = '0;
    logic                 word_start = 1'b0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [FIRED_W-1:0]   rule_fired;
    logic [STATUS_W-1:0]  status;

    int    fail_count;
    int    pending;
    int    cycle_count = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    bit    hold_arm = 1'b0;
    bit    hold_done = 1'b0;
    int    hold_left = 0;
    logic  item_taken = 1'b0;
    char_t char_q [$];

    ll1_simple_grammar_parser u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .reg_index    (reg_index),
        .wr_data      (wr_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .symbol       (symbol),
        .word_start   (word_start),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .rule_fired   (rule_fired),
        .status       (status)
    );

    parse_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .reg_index    (reg_index),
        .wr_data      (wr_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .symbol       (symbol),
        .word_start   (word_start),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .rule_fired   (rule_fired),
        .status       (status),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        item_taken <= item_valid && item_ready;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long stall on request.
    always @(negedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [RULE_W-1:0] pack_rule(input logic [SYM_W-1:0] lhs,
                                                    input logic [1:0] len,
                                                    input logic [SYM_W-1:0] c0,
                                                    input logic [SYM_W-1:0] c1,
                                                    input logic [SYM_W-1:0] c2);
        return {c2, c1, c0, len, lhs};
    endfunction

    function automatic void queue_char(input logic [SYM_W-1:0] s, input logic ws);
        char_t c;
        c.sym = s;
        c.ws  = ws;
        char_q.insert(char_q.size(), c);
    endfunction

    function automatic logic [SYM_W-1:0] pick_char(input bit edge_set);
        if (edge_set)
        begin
            case ($urandom_range(4))
                0:       return LC_A;
                1:       return LC_X;
                2:       return LC_Y;
                3:       return LC_Q;
                default: return END_MARK;
            endcase
        end
        case ($urandom_range(4))
            0:       return LC_A;
            1:       return LC_B;
            2:       return LC_C;
            3:       return LC_D;
            default: return END_MARK;
        endcase
    endfunction

    // Sentence of the reset grammar, a^n b^m d c^m #, sometimes damaged.
    // Long runs of b drive the stack to its limit and past it.
    task automatic add_default_word();
        logic [SYM_W-1:0] w [$];
        int               n_a;
        int               n_b;
        int               flaw;
        n_a = $urandom_range(0, 3);
        n_b = ($urandom_range(7) == 0) ? $urandom_range(12, 16) : $urandom_range(1, 4);
        flaw = $urandom_range(0, 9);
        repeat (n_a) w.insert(w.size(), LC_A);
        repeat (n_b) w.insert(w.size(), LC_B);
        w.insert(w.size(), LC_D);
        repeat (n_b) w.insert(w.size(), LC_C);
        w.insert(w.size(), END_MARK);
        if (flaw == 0)
            w[$urandom_range(0, w.size() - 1)] = 8'($urandom_range(0, 255));
        else if (flaw == 1)
            repeat ($urandom_range(1, w.size() - 1)) void'(w.pop_back());
        else if (flaw == 2)
            w.insert(w.size(), 8'($urandom_range(0, 255)));
        for (int i = 0; i < w.size(); i++)
            queue_char(w[i], i == 0);
    endtask

    task automatic add_scrambled_word(input bit edge_set);
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            queue_char(pick_char(edge_set), i == 0);
    endtask

    task automatic play_chars();
        char_t c;
        while (char_q.size() > 0)
        begin
            c = char_q.pop_front();
            while ($urandom_range(99) < send_idle_pct)
            begin
                item_valid <= 1'b0;
                @(negedge clk);
            end
            item_valid <= 1'b1;
            symbol <= c.sym;
            word_start <= c.ws;
            @(negedge clk);
            while (!item_taken)
                @(negedge clk);
        end
        item_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RULE_W-1:0] val);
        wr_en <= 1'b1;
        reg_index <= idx;
        wr_data <= val;
        @(negedge clk);
    endtask

    task automatic load_grammar(input logic [RULE_W-1:0] r1, input logic [RULE_W-1:0] r2,
                                input logic [RULE_W-1:0] r3, input logic [RULE_W-1:0] r4,
                                input logic [SYM_W-1:0] start);
        wait_idle();
        put_reg(REG_RULE_ONE, r1);
        put_reg(REG_RULE_TWO, r2);
        put_reg(REG_RULE_THREE, r3);
        put_reg(REG_RULE_FOUR, r4);
        put_reg(REG_START_SYMBOL, {{(RULE_W - SYM_W){1'b0}}, start});
        wr_en <= 1'b0;
    endtask

    task automatic random_grammar_phase(input int n_items);
        logic [RULE_W-1:0] r [RULE_REGS];
        for (int i = 0; i < RULE_REGS; i++)
            r[i] = pack_rule(($urandom_range(1) == 0) ? UC_S : UC_A,
                             2'($urandom_range(0, 3)), pick_char(1'b0),
                             ($urandom_range(2) == 0) ? UC_A : pick_char(1'b0),
                             ($urandom_range(2) == 0) ? UC_S : pick_char(1'b0));
        load_grammar(r[0], r[1], r[2], r[3], ($urandom_range(3) == 0) ? UC_A : UC_S);
        while (char_q.size() < n_items)
            add_scrambled_word(1'b0);
        play_chars();
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset grammar, untouched registers.
        send_idle_pct = 23;
        recv_idle_pct = 49;
        queue_char(LC_B, 1'b1);
        queue_char(LC_D, 1'b0);
        queue_char(LC_C, 1'b0);
        queue_char(END_MARK, 1'b0);
        queue_char(LC_A, 1'b0);
        queue_char(LC_A, 1'b1);
        queue_char(LC_A, 1'b0);
        queue_char(LC_B, 1'b0);
        queue_char(LC_B, 1'b0);
        queue_char(LC_D, 1'b0);
        queue_char(LC_C, 1'b0);
        queue_char(LC_C, 1'b0);
        queue_char(END_MARK, 1'b0);
        queue_char(8'h00, 1'b1);
        queue_char(8'hFF, 1'b1);
        queue_char(END_MARK, 1'b1);
        queue_char(LC_D, 1'b1);
        queue_char(LC_C, 1'b0);
        while (char_q.size() < 260)
            add_default_word();
        play_chars();

        // Rules that empty the stack, a rule that starts with the end marker,
        // and an unused rule that would otherwise clash.
        load_grammar(pack_rule(UC_S, 2'd1, LC_A, 8'h00, 8'h00),
                     pack_rule(END_MARK, 2'd1, LC_X, 8'h00, 8'h00),
                     pack_rule(UC_S, 2'd2, END_MARK, LC_Q, 8'h00),
                     pack_rule(UC_S, 2'd0, LC_A, UC_A, 8'h00),
                     UC_S);
        queue_char(LC_A, 1'b1);
        queue_char(LC_X, 1'b0);
        queue_char(LC_Y, 1'b0);
        queue_char(LC_Y, 1'b0);
        queue_char(END_MARK, 1'b1);
        queue_char(LC_Q, 1'b1);
        queue_char(LC_A, 1'b1);
        queue_char(END_MARK, 1'b0);
        while (char_q.size() < 110)
            add_scrambled_word(1'b1);
        play_chars();

        // A rule that starts with a nonterminal spoils the whole set.
        send_idle_pct = 49;
        recv_idle_pct = 23;
        load_grammar(RULE_ONE_DEFAULT, RULE_TWO_DEFAULT, RULE_THREE_DEFAULT,
                     pack_rule(UC_A, 2'd1, UC_B, 8'h00, 8'h00), UC_A);
        queue_char(LC_B, 1'b1);
        queue_char(LC_D, 1'b0);
        queue_char(END_MARK, 1'b0);
        queue_char(LC_A, 1'b1);
        queue_char(8'($urandom_range(0, 255)), 1'b0);
        play_chars();

        // All ones: four identical rules, so first characters collide.
        load_grammar({RULE_W{1'b1}}, {RULE_W{1'b1}}, {RULE_W{1'b1}}, {RULE_W{1'b1}}, 8'hFF);
        queue_char(8'hFF, 1'b1);
        queue_char(END_MARK, 1'b0);
        queue_char(8'h00, 1'b1);
        play_chars();

        // No rules at all; only direct matches against the stack can work.
        load_grammar('0, '0, '0, '0, 8'h00);
        queue_char(8'h00, 1'b1);
        queue_char(END_MARK, 1'b0);
        queue_char(8'hFF, 1'b1);
        queue_char(END_MARK, 1'b1);
        while (char_q.size() < 40)
            queue_char(($urandom_range(3) == 0) ? END_MARK : 8'($urandom_range(0, 255)),
                       $urandom_range(3) == 0);
        play_chars();

        repeat (4) random_grammar_phase(50);

        // Back to the reset grammar, no idling, and one long result stall
        // while characters keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_grammar(RULE_ONE_DEFAULT, RULE_TWO_DEFAULT, RULE_THREE_DEFAULT,
                     RULE_FOUR_DEFAULT, START_DEFAULT);
        while (char_q.size() < 200)
            add_default_word();
        hold_arm = 1'b1;
        play_chars();

        wait_idle();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
